FILE: src/key_debounce_long_press_assert.svh
// Assertion macros shared by the key debounce RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Checks a property in the same cycle, outside of reset.
`define KDLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key debounce check failed");

// Checks a property in the cycle after its trigger, outside of reset.
`define KDLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key debounce check failed");

`endif

FILE: src/kdlp_pkg.sv
// Shared types and constants of the key debounce and long-press block.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package kdlp_pkg;

  // Number of keys, one lane each.
  localparam int unsigned NumKeys = 4;

  localparam int unsigned TimerW = 16;
  localparam int unsigned IncW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TICK_INC   = 2'd3;

  // Per-key event codes.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } key_ev_e;

  // Configuration seen by every lane.
  typedef struct packed {
    logic [TimerW-1:0] debounce_time;
    logic [TimerW-1:0] long_press_time;
    logic              active_low;
    logic [IncW-1:0]   tick_increment;
  } kdlp_cfg_t;

  // Events of all lanes for one beat.
  typedef key_ev_e [NumKeys-1:0] key_ev_vec_t;

endpackage

`default_nettype wire

FILE: src/kdlp_lane.sv
// One key lane: six-phase debounce machine with a saturating timer.
// Depends on kdlp_pkg and the assertion macro header.
`default_nettype none
`include "key_debounce_long_press_assert.svh"

module kdlp_lane import kdlp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       level_i,
  input  wire kdlp_cfg_t  cfg_i,
  output key_ev_e         ev_o
);

  // Phase codes.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_DOWN     = 3'd1;
  localparam logic [2:0] PH_LONG     = 3'd2;
  localparam logic [2:0] PH_BOUNCE   = 3'd3;
  localparam logic [2:0] PH_REL_DOWN = 3'd4;
  localparam logic [2:0] PH_REL_LONG = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [TimerW:0]   sum;
  logic [TimerW-1:0] adv;
  logic              pressed;
  key_ev_e           ev;

  // Level polarity.
  assign pressed = level_i ^ cfg_i.active_low;

  // Saturating timer advance.
  assign sum = {1'b0, timer_q} + {{(TimerW + 1 - IncW){1'b0}}, cfg_i.tick_increment};
  assign adv = sum[TimerW] ? {TimerW{1'b1}} : sum[TimerW-1:0];

  // Next phase, timer and event.
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    ev      = EV_NONE;
    if (pressed) begin
      case (phase_q)
        PH_BOUNCE: begin
          timer_d = adv;
          if (adv >= cfg_i.debounce_time) begin
            phase_d = PH_DOWN;
            ev      = EV_PRESS;
          end
        end
        PH_DOWN: begin
          timer_d = adv;
          if (adv >= cfg_i.long_press_time) begin
            phase_d = PH_LONG;
            ev      = EV_LONG;
          end
        end
        PH_LONG: begin
        end
        PH_REL_DOWN: begin
          phase_d = PH_DOWN;
          timer_d = '0;
        end
        PH_REL_LONG: begin
          phase_d = PH_LONG;
          timer_d = '0;
        end
        default: begin
          phase_d = PH_BOUNCE;
          timer_d = '0;
        end
      endcase
    end else begin
      case (phase_q)
        PH_BOUNCE: begin
          phase_d = PH_IDLE;
          timer_d = '0;
        end
        PH_DOWN: begin
          phase_d = PH_REL_DOWN;
          timer_d = '0;
        end
        PH_LONG: begin
          phase_d = PH_REL_LONG;
          timer_d = '0;
        end
        PH_REL_DOWN, PH_REL_LONG: begin
          timer_d = adv;
          if (adv >= cfg_i.debounce_time) begin
            phase_d = PH_IDLE;
            timer_d = '0;
            ev      = EV_RELEASE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // State advances once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

  assign ev_o = ev;

  `KDLP_ASSERT_NOW(a_idle_timer_clear, phase_q == PH_IDLE, timer_q == '0)
  `KDLP_ASSERT_NEXT(a_press_to_down, en_i && ev == EV_PRESS, phase_q == PH_DOWN)
  `KDLP_ASSERT_NEXT(a_release_to_idle, en_i && ev == EV_RELEASE,
                    phase_q == PH_IDLE && timer_q == '0)

endmodule

`default_nettype wire

FILE: src/kdlp_merge.sv
// Merge stage: gathers the lane events of one beat into the output register.
// Depends on kdlp_pkg and the assertion macro header.
`default_nettype none
`include "key_debounce_long_press_assert.svh"

module kdlp_merge import kdlp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire key_ev_vec_t lane_ev_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output key_ev_vec_t      out_ev_o
);

  logic        valid_q, valid_d;
  key_ev_vec_t ev_q;
  logic        take;

  // A new beat enters whenever the held result is gone or leaves this cycle.
  assign in_stall_o = valid_q && out_stall_i;
  assign take       = in_valid_i && !in_stall_o;
  assign valid_d    = take || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ev_q <= lane_ev_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ev_o    = ev_q;

  `KDLP_ASSERT_NEXT(a_take_gives_valid, take, valid_q)
  `KDLP_ASSERT_NEXT(a_idle_drains, !take && !(valid_q && out_stall_i), !valid_q)
  `KDLP_ASSERT_NEXT(a_stall_holds, valid_q && out_stall_i, valid_q && $stable(ev_q))

endmodule

`default_nettype wire

FILE: src/key_debounce_long_press.sv
// Top level of the four-key debounce and long-press detector.
// Depends on kdlp_pkg, kdlp_lane and kdlp_merge.
//
//  channel   direction  handshake               payload
//  input     in         in_valid_i / in_stall_o   key_levels_i[3:0]
//  result    out        out_valid_o / out_stall_i key0..key3_event_o[1:0]
//  config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One beat per cycle while the input is not stalled: every key has its own lane, so all keys update together.
// A result appears in the output register in the cycle after its input beat is accepted.
// Input stalls only while that register is full and the output is stalled.
// Reset puts every key in idle with a zero timer and loads the default setup.
`default_nettype none

module key_debounce_long_press import kdlp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [NumKeys-1:0]  key_levels_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               key0_event_o,
  output logic [1:0]               key1_event_o,
  output logic [1:0]               key2_event_o,
  output logic [1:0]               key3_event_o
);

  kdlp_cfg_t   cfg_q;
  key_ev_vec_t lane_ev;
  key_ev_vec_t out_ev;
  logic        accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time   <= 16'd6;
      cfg_q.long_press_time <= 16'd1000;
      cfg_q.active_low      <= 1'b1;
      cfg_q.tick_increment  <= 10'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce_time   <= cfg_data_i;
        CFG_LONG_PRESS: cfg_q.long_press_time <= cfg_data_i;
        CFG_ACTIVE_LOW: cfg_q.active_low      <= cfg_data_i[0];
        CFG_TICK_INC:   cfg_q.tick_increment  <= cfg_data_i[IncW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  // One lane per key.
  for (genvar k = 0; k < NumKeys; k++) begin : g_lane
    kdlp_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .level_i (key_levels_i[k]),
      .cfg_i   (cfg_q),
      .ev_o    (lane_ev[k])
    );
  end

  kdlp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .lane_ev_i   (lane_ev),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ev_o    (out_ev)
  );

  assign key0_event_o = out_ev[0];
  assign key1_event_o = out_ev[1];
  assign key2_event_o = out_ev[2];
  assign key3_event_o = out_ev[3];

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for key_debounce_long_press, the four-key debounce block.
// It needs kdlp_pkg and the RTL. A scoreboard class predicts every key event,
// and plain tasks drive ticks and register setups with random gaps and stalls.

module tb;
  import kdlp_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // Phases that each key's debounce machine walks through.
  typedef enum logic [2:0] {
    KEY_IDLE,
    KEY_BOUNCE,
    KEY_DOWN,
    KEY_HELD,
    KEY_REL_DOWN,
    KEY_REL_HELD
  } key_phase_e;

  // Predicts the per-key events of every tick and checks each result beat.
  class key_event_board;
    key_phase_e       phase [NumKeys];
    logic [15:0]      timer [NumKeys];
    logic [15:0]      debounce_t;
    logic [15:0]      long_t;
    logic             active_low;
    logic [9:0]       tick_inc;
    key_ev_vec_t      expected_q [$];
    int               errors;
    int               ticks_seen;
    int               results_seen;
    int               n_press;
    int               n_long;
    int               n_release;

    function new();
      debounce_t = 16'd6;
      long_t     = 16'd1000;
      active_low = 1'b1;
      tick_inc   = 10'd10;
      for (int k = 0; k < NumKeys; k++) begin
        phase[k] = KEY_IDLE;
        timer[k] = '0;
      end
    endfunction

    function void set_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      case (idx)
        CFG_DEBOUNCE:   debounce_t = data;
        CFG_LONG_PRESS: long_t = data;
        CFG_ACTIVE_LOW: active_low = data[0];
        CFG_TICK_INC:   tick_inc = data[9:0];
        default: ;
      endcase
    endfunction

    // The timer saturates instead of wrapping.
    function logic [15:0] timer_add(input logic [15:0] t);
      logic [16:0] sum;
      sum = {1'b0, t} + {7'b0, tick_inc};
      return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function key_ev_e step_key(input int k, input bit pressed);
      key_ev_e ev;
      ev = EV_NONE;
      if (pressed) begin
        case (phase[k])
          KEY_BOUNCE: begin
            timer[k] = timer_add(timer[k]);
            if (timer[k] >= debounce_t) begin
              phase[k] = KEY_DOWN;
              ev = EV_PRESS;
            end
          end
          KEY_DOWN: begin
            timer[k] = timer_add(timer[k]);
            if (timer[k] >= long_t) begin
              phase[k] = KEY_HELD;
              ev = EV_LONG;
            end
          end
          KEY_HELD: ;
          // A press during release bounce restores the down or held phase that the key left.
          KEY_REL_DOWN: begin
            timer[k] = '0;
            phase[k] = KEY_DOWN;
          end
          KEY_REL_HELD: begin
            timer[k] = '0;
            phase[k] = KEY_HELD;
          end
          default: begin
            phase[k] = KEY_BOUNCE;
            timer[k] = '0;
          end
        endcase
      end else begin
        case (phase[k])
          KEY_BOUNCE: begin
            phase[k] = KEY_IDLE;
            timer[k] = '0;
          end
          KEY_DOWN: begin
            phase[k] = KEY_REL_DOWN;
            timer[k] = '0;
          end
          KEY_HELD: begin
            phase[k] = KEY_REL_HELD;
            timer[k] = '0;
          end
          KEY_REL_DOWN, KEY_REL_HELD: begin
            timer[k] = timer_add(timer[k]);
            if (timer[k] >= debounce_t) begin
              phase[k] = KEY_IDLE;
              timer[k] = '0;
              ev = EV_RELEASE;
            end
          end
          default: phase[k] = KEY_IDLE;
        endcase
      end
      return ev;
    endfunction

    // Called for every accepted input beat.
    function void note_tick(input logic [NumKeys-1:0] levels);
      key_ev_vec_t want;
      for (int k = 0; k < NumKeys; k++) begin
        want[k] = step_key(k, levels[k] ^ active_low);
        if (want[k] == EV_PRESS) n_press++;
        if (want[k] == EV_LONG) n_long++;
        if (want[k] == EV_RELEASE) n_release++;
      end
      expected_q.push_back(want);
      ticks_seen++;
    endfunction

    // Called for every accepted result beat.
    function void check_result(input logic [1:0] e0, e1, e2, e3);
      logic [1:0]  got [NumKeys];
      key_ev_vec_t want;
      got = '{e0, e1, e2, e3};
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("Result beat arrived with no tick waiting for it");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int k = 0; k < NumKeys; k++) begin
        if (got[k] !== want[k]) begin
          $error("key%0d_event: expected %0d, got %0d", k, want[k], got[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_DEBOUNCE;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [NumKeys-1:0]  key_levels_i = '1;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          key0_event_o;
  logic [1:0]          key1_event_o;
  logic [1:0]          key2_event_o;
  logic [1:0]          key3_event_o;

  key_event_board sb = new();

  int          cycle_count = 0;
  int          setups = 0;
  bit          sender_calm = 1'b0;
  int          stall_left = 0;
  int          calm_left = 0;
  int          sink_roll;
  int          hold_left [NumKeys] = '{default: 0};
  bit          key_down [NumKeys] = '{default: 1'b0};

  // Directed ticks under the reset setup: press, a release bounce that is
  // pressed again, full release, and a press bounce that is abandoned.
  logic [3:0] reset_seq [9] = '{4'hF, 4'h0, 4'h0, 4'hA, 4'h0, 4'hF, 4'hF, 4'h5, 4'hF};
  // Directed ticks with all thresholds and the increment at zero, active high.
  logic [3:0] zero_seq [8] = '{4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};

  key_debounce_long_press DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key0_event_o (key0_event_o),
    .key1_event_o (key1_event_o),
    .key2_event_o (key2_event_o),
    .key3_event_o (key3_event_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, sb.pending());
    $display("== FAIL ==");
    $finish;
  end

  // Result side: check accepted beats and stall in short and long bursts,
  // with calm stretches where it never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(key0_event_o, key1_event_o, key2_event_o, key3_event_o);
    end
    if (calm_left > 0) begin
      calm_left--;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      out_stall_i <= 1'b0;
      if (sink_roll < 3) calm_left = $urandom_range(50, 200);
      else if (sink_roll < 20) stall_left = $urandom_range(1, 3);
      else if (sink_roll < 22) stall_left = $urandom_range(10, 40);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Hold lengths sized to the current setup so that presses, long presses
  // and releases are confirmed, and short holds give bounce.
  function automatic int pick_hold();
    int t_db;
    int t_lp;
    int r;
    t_db = (sb.tick_inc == 0) ? 2 : int'(sb.debounce_t) / int'(sb.tick_inc) + 2;
    t_lp = (sb.tick_inc == 0) ? 2 : int'(sb.long_t) / int'(sb.tick_inc) + 2;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 3);
    if (r < 65) return t_db + $urandom_range(0, 3);
    if (r < 85) return t_db + t_lp + $urandom_range(0, 4);
    return $urandom_range(4, 12);
  endfunction

  // Each key holds a level for a while, then mostly toggles; rare one-tick glitches.
  function automatic logic [NumKeys-1:0] next_levels();
    logic [NumKeys-1:0] lv;
    for (int k = 0; k < NumKeys; k++) begin
      if (hold_left[k] == 0) begin
        if ($urandom_range(0, 99) < 85) key_down[k] = !key_down[k];
        hold_left[k] = pick_hold();
      end
      hold_left[k]--;
      lv[k] = key_down[k] ^ sb.active_low;
      if ($urandom_range(0, 99) < 4) lv[k] = !lv[k];
    end
    return lv;
  endfunction

  task automatic send_tick(input logic [NumKeys-1:0] levels, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_levels_i <= levels;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_tick(levels);
  endtask

  // Sender pauses until every predicted result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_cfg(idx, data);
  endtask

  task automatic apply_setup(input logic [15:0] db_v, lp_v, al_v, inc_v);
    write_reg(CFG_DEBOUNCE, db_v);
    write_reg(CFG_LONG_PRESS, lp_v);
    write_reg(CFG_ACTIVE_LOW, al_v);
    write_reg(CFG_TICK_INC, inc_v);
    cfg_we_i <= 1'b0;
    setups++;
  endtask

  task automatic run_phase(input logic [15:0] db_v, lp_v, al_v, inc_v,
                           input int n_items, input bit noise);
    logic [NumKeys-1:0] levels;
    wait_drained();
    apply_setup(db_v, lp_v, al_v, inc_v);
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      levels = noise ? NumKeys'($urandom_range(0, 15)) : next_levels();
      send_tick(levels, pick_gap());
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset setup first, then every threshold at zero.
    foreach (reset_seq[i]) send_tick(reset_seq[i], pick_gap());
    wait_drained();
    apply_setup(16'd0, 16'd0, 16'd0, 16'd0);
    foreach (zero_seq[i]) send_tick(zero_seq[i], pick_gap());

    // Random part over several setups, extremes included. An increment
    // written as all ones keeps its low ten bits, 1023, and drives the
    // timers into saturation.
    run_phase(16'd20, 16'd200, 16'd1, 16'd10, 150, 1'b0);
    run_phase(16'd0, 16'd30, 16'd0, 16'd1, 150, 1'b0);
    run_phase(16'd3000, 16'hFFFF, 16'd1, 16'hFFFF, 150, 1'b0);
    run_phase(16'hFFFF, 16'd0, 16'd0, 16'd1000, 120, 1'b0);
    run_phase(16'd5, 16'd5, 16'd1, 16'd0, 40, 1'b0);
    for (int p = 0; p < 3; p++) begin
      run_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 2000)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1000)), 80, 1'b0);
    end
    run_phase(16'd6, 16'd1000, 16'd1, 16'd10, 60, 1'b1);
    wait_drained();

    $display("Covered %0d ticks over %0d register setups: %0d presses, %0d long presses, %0d releases.",
             sb.ticks_seen, setups, sb.n_press, sb.n_long, sb.n_release);
    $display("Checked %0d result beats against predicted key events, %0d mismatches.",
             sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
